// ----- rtl/core/tcrt_pkg.sv -----
package tcrt_pkg;

	// Default number of tracked contacts
	localparam int MAX_POINTS_DEF = 10;
	// Identifier sent on an empty report word
	localparam logic [6:0] NO_ID = 7'h7F;

	// One input word: a touch point of the current frame
	typedef struct packed {
		logic        point_valid;
		logic        contact;
		logic [6:0]  point_id;
		logic [15:0] pos_x;
		logic [15:0] pos_y;
		logic [7:0]  contact_width;
		logic [7:0]  contact_height;
		logic [7:0]  pressure;
		logic        last_in_frame;
	} in_word_t;

	// One report word
	typedef struct packed {
		logic        out_valid;
		logic        out_contact;
		logic [6:0]  out_id;
		logic [15:0] out_x;
		logic [15:0] out_y;
		logic [7:0]  out_width;
		logic [7:0]  out_height;
		logic [7:0]  out_pressure;
		logic        is_release;
		logic        end_of_report;
	} out_word_t;

	// Stored point, 64 bits, contact flag in bit 0
	typedef struct packed {
		logic [7:0]  pressure;
		logic [7:0]  c_height;
		logic [7:0]  c_width;
		logic [15:0] pos_y;
		logic [15:0] pos_x;
		logic [6:0]  id;
		logic        contact;
	} point_t;

	// Controller to datapath commands
	typedef struct packed {
		logic capture;    // load input word
		logic store;      // write point into current bank, count it
		logic push_out;   // point straight to output register
		logic to_pend;    // point into pending slot
		logic scan_start; // clear found flags, reset scan index
		logic scan_rd;    // read previous bank entry
		logic scan_chk;   // check entry read, advance scan index
		logic rel_start;  // reset release index
		logic rel_rd;     // read first entry of release candidate
		logic rel_emit;   // append release, move pending word on
		logic rel_next;   // advance release index
		logic rel_end;    // active mask takes the frame mask
		logic finish;     // close report, swap banks
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic item_last;
		logic store_ok;
		logic both_empty;
		logic cnt_ne_prev;
		logic ofree;
		logic pend_valid;
		logic scan_done;
		logic rel_ok;
		logic rel_last;
	} sts_t;

	function automatic point_t item_point(in_word_t w);
		point_t p;
		p.pressure = w.pressure;
		p.c_height = w.contact_height;
		p.c_width  = w.contact_width;
		p.pos_y    = w.pos_y;
		p.pos_x    = w.pos_x;
		p.id       = w.point_id;
		p.contact  = w.contact;
		return p;
	endfunction

	function automatic out_word_t mk_out(point_t p, logic rel, logic eor);
		out_word_t o;
		o.out_valid     = 1'b1;
		o.out_contact   = p.contact;
		o.out_id        = p.id;
		o.out_x         = p.pos_x;
		o.out_y         = p.pos_y;
		o.out_width     = p.c_width;
		o.out_height    = p.c_height;
		o.out_pressure  = p.pressure;
		o.is_release    = rel;
		o.end_of_report = eor;
		return o;
	endfunction

	function automatic out_word_t empty_out();
		out_word_t o;
		o = '0;
		o.out_id        = NO_ID;
		o.end_of_report = 1'b1;
		return o;
	endfunction

endpackage

// ----- rtl/core/tcrt_ctrl.sv -----
module tcrt_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           pt_valid,
	output logic           pt_ready,
	input  tcrt_pkg::sts_t sts,
	output tcrt_pkg::cmd_t cmd
);
	import tcrt_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_POINT,
		S_DECIDE,
		S_SCAN_RD,
		S_SCAN_CHK,
		S_REL_RD,
		S_REL_EMIT,
		S_FINISH
	} state_t;

	state_t state_q, state_d;

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		pt_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				pt_ready    = 1'b1;
				cmd.capture = pt_valid;
				if (pt_valid) state_d = S_POINT;
			end
			S_POINT: begin
				if (sts.store_ok && !sts.item_last) begin
					// mid-frame point goes out directly
					if (sts.ofree) begin
						cmd.store    = 1'b1;
						cmd.push_out = 1'b1;
						state_d      = S_IDLE;
					end
				end else if (sts.store_ok) begin
					cmd.store   = 1'b1;
					cmd.to_pend = 1'b1;
					state_d     = S_DECIDE;
				end else begin
					state_d = sts.item_last ? S_DECIDE : S_IDLE;
				end
			end
			S_DECIDE: begin
				if (sts.both_empty) begin
					state_d = S_IDLE;
				end else if (sts.cnt_ne_prev) begin
					cmd.scan_start = 1'b1;
					state_d        = S_SCAN_RD;
				end else begin
					state_d = S_FINISH;
				end
			end
			S_SCAN_RD: begin
				if (sts.scan_done) begin
					cmd.rel_start = 1'b1;
					state_d       = S_REL_RD;
				end else begin
					cmd.scan_rd = 1'b1;
					state_d     = S_SCAN_CHK;
				end
			end
			S_SCAN_CHK: begin
				cmd.scan_chk = 1'b1;
				state_d      = S_SCAN_RD;
			end
			S_REL_RD: begin
				if (sts.rel_ok) begin
					cmd.rel_rd = 1'b1;
					state_d    = S_REL_EMIT;
				end else if (sts.rel_last) begin
					cmd.rel_end = 1'b1;
					state_d     = S_FINISH;
				end else begin
					cmd.rel_next = 1'b1;
				end
			end
			S_REL_EMIT: begin
				// pending word needs a free output register to move on
				if (!sts.pend_valid || sts.ofree) begin
					cmd.rel_emit = 1'b1;
					if (sts.rel_last) begin
						cmd.rel_end = 1'b1;
						state_d     = S_FINISH;
					end else begin
						cmd.rel_next = 1'b1;
						state_d      = S_REL_RD;
					end
				end
			end
			S_FINISH: begin
				if (sts.ofree) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ----- rtl/core/tcrt_dp.sv -----
module tcrt_dp #(
	parameter int MAX_POINTS = tcrt_pkg::MAX_POINTS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  tcrt_pkg::in_word_t  pt_word,
	input  tcrt_pkg::cmd_t      cmd,
	output tcrt_pkg::sts_t      sts,
	output logic                rpt_valid,
	input  logic                rpt_ready,
	output tcrt_pkg::out_word_t rpt_word
);
	import tcrt_pkg::*;

	localparam int CNTW  = $clog2(MAX_POINTS + 1);
	localparam int IDXW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int DEPTH = 2 * MAX_POINTS;
	localparam int ADDRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	in_word_t             item_q;
	logic                 bank_q;
	logic [CNTW-1:0]      cur_cnt_q, prev_cnt_q;
	logic [MAX_POINTS-1:0] active_q, frame_q, found_q;
	logic [CNTW-1:0]      first_q [MAX_POINTS];
	logic [CNTW-1:0]      j_q;
	logic [IDXW-1:0]      i_q;
	point_t               mem [DEPTH];
	point_t               rd_q;
	point_t               pend_q;
	logic                 pend_rel_q, pend_valid_q;
	out_word_t            out_q;
	logic                 out_valid_q;

	logic [ADDRW-1:0]     cur_base, prev_base, wr_addr, rd_addr;
	logic [MAX_POINTS-1:0] released;
	point_t               item_pt, rel_pt, wr_data;
	logic                 ofree, item_tracked, rd_tracked;
	logic [IDXW-1:0]      item_idx, rd_idx;

	assign cur_base  = bank_q ? ADDRW'(MAX_POINTS) : '0;
	assign prev_base = bank_q ? '0 : ADDRW'(MAX_POINTS);
	assign released  = active_q & ~frame_q;
	assign item_pt   = item_point(item_q);
	assign ofree     = !out_valid_q || rpt_ready;

	assign item_tracked = item_q.point_id < 7'(MAX_POINTS);
	assign item_idx     = item_q.point_id[IDXW-1:0];
	assign rd_tracked   = rd_q.id < 7'(MAX_POINTS);
	assign rd_idx       = rd_q.id[IDXW-1:0];

	// release copy of a previous point, contact cleared
	always_comb begin
		rel_pt         = rd_q;
		rel_pt.contact = 1'b0;
	end

	// status to controller
	assign sts.item_last   = item_q.last_in_frame;
	assign sts.store_ok    = item_q.point_valid && (cur_cnt_q < CNTW'(MAX_POINTS));
	assign sts.both_empty  = (cur_cnt_q == '0) && (prev_cnt_q == '0);
	assign sts.cnt_ne_prev = cur_cnt_q != prev_cnt_q;
	assign sts.ofree       = ofree;
	assign sts.pend_valid  = pend_valid_q;
	assign sts.scan_done   = j_q == prev_cnt_q;
	assign sts.rel_ok      = found_q[i_q] && (cur_cnt_q < CNTW'(MAX_POINTS));
	assign sts.rel_last    = i_q == IDXW'(MAX_POINTS - 1);

	// point store addressing
	assign wr_addr = cur_base + ADDRW'(cur_cnt_q);
	assign wr_data = cmd.store ? item_pt : rel_pt;
	assign rd_addr = cmd.rel_rd ? (prev_base + ADDRW'(first_q[i_q]))
	                            : (prev_base + ADDRW'(j_q));

	// point store, one write and one registered read
	always_ff @(posedge clk) begin
		if (cmd.store || cmd.rel_emit) mem[wr_addr] <= wr_data;
		if (cmd.scan_rd || cmd.rel_rd) rd_q <= mem[rd_addr];
	end

	// input word and payload registers
	always_ff @(posedge clk) begin
		if (cmd.capture) item_q <= pt_word;
		if (cmd.scan_chk && rd_tracked && released[rd_idx] && !found_q[rd_idx])
			first_q[rd_idx] <= j_q;
		if (cmd.to_pend) begin
			pend_q     <= item_pt;
			pend_rel_q <= 1'b0;
		end else if (cmd.rel_emit) begin
			pend_q     <= rel_pt;
			pend_rel_q <= 1'b1;
		end
		if (cmd.push_out) begin
			out_q <= mk_out(item_pt, 1'b0, 1'b0);
		end else if (cmd.rel_emit && pend_valid_q) begin
			out_q <= mk_out(pend_q, pend_rel_q, 1'b0);
		end else if (cmd.finish) begin
			out_q <= pend_valid_q ? mk_out(pend_q, pend_rel_q, 1'b1) : empty_out();
		end
	end

	// frame and report bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_q       <= 1'b0;
			cur_cnt_q    <= '0;
			prev_cnt_q   <= '0;
			active_q     <= '0;
			frame_q      <= '0;
			found_q      <= '0;
			j_q          <= '0;
			i_q          <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.store || cmd.rel_emit) cur_cnt_q <= cur_cnt_q + 1'b1;
			if (cmd.store && item_tracked) frame_q[item_idx] <= 1'b1;
			if (cmd.scan_start) begin
				found_q <= '0;
				j_q     <= '0;
			end
			if (cmd.scan_chk) begin
				j_q <= j_q + 1'b1;
				if (rd_tracked && released[rd_idx]) found_q[rd_idx] <= 1'b1;
			end
			if (cmd.rel_start) i_q <= '0;
			if (cmd.rel_next)  i_q <= i_q + 1'b1;
			if (cmd.rel_end)   active_q <= frame_q;
			if (cmd.to_pend || cmd.rel_emit) pend_valid_q <= 1'b1;
			if (cmd.finish) begin
				prev_cnt_q   <= cur_cnt_q;
				bank_q       <= ~bank_q;
				cur_cnt_q    <= '0;
				frame_q      <= '0;
				pend_valid_q <= 1'b0;
			end
			if (cmd.push_out || (cmd.rel_emit && pend_valid_q) || cmd.finish)
				out_valid_q <= 1'b1;
			else if (rpt_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign rpt_valid = out_valid_q;
	assign rpt_word  = out_q;

`ifndef ASSERT_OFF
	a_cur_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		cur_cnt_q <= CNTW'(MAX_POINTS))
		else $error("current count beyond capacity");
	a_prev_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		prev_cnt_q <= CNTW'(MAX_POINTS))
		else $error("previous count beyond capacity");
	a_finish: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> (cur_cnt_q == '0) && (frame_q == '0) && !pend_valid_q)
		else $error("frame state not cleared at report end");
	a_direct: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push_out |-> !pend_valid_q)
		else $error("direct point while a report word is pending");
`endif

endmodule

// ----- rtl/core/touch_contact_release_tracker.sv -----
// Touch contact release tracker.
// Input channel pt_valid/pt_ready/pt_word carries the touch points of one
// frame, the final word marked last_in_frame; an empty frame is one word
// with point_valid low and the mark set. Output channel
// rpt_valid/rpt_ready/rpt_word carries the report words.
// A mid-frame point is written to the output register once that is free,
// and the controller then returns to idle to take the next word.
// At frame end the controller decides: with both banks empty it goes back
// to idle without a report; if the count changed, the previous bank is
// scanned through the single read port of the point store and then
// MAX_POINTS release candidates are walked; then the report is closed, and
// its last word carries end_of_report.
// Reset clears counts, masks and the bank select; the point store needs
// no clearing, as only written entries are read.
// A stalled receiver holds the output register; the controller then waits
// in place and accepts no new word until its current one is done.
module touch_contact_release_tracker #(
	parameter int MAX_POINTS = tcrt_pkg::MAX_POINTS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                pt_valid,
	output logic                pt_ready,
	input  tcrt_pkg::in_word_t  pt_word,
	output logic                rpt_valid,
	input  logic                rpt_ready,
	output tcrt_pkg::out_word_t rpt_word
);
	import tcrt_pkg::*;

	cmd_t cmd;
	sts_t sts;

	tcrt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.pt_valid (pt_valid),
		.pt_ready (pt_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	tcrt_dp #(
		.MAX_POINTS (MAX_POINTS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.pt_word   (pt_word),
		.cmd       (cmd),
		.sts       (sts),
		.rpt_valid (rpt_valid),
		.rpt_ready (rpt_ready),
		.rpt_word  (rpt_word)
	);

endmodule
